// File: sv/rbsu_pkg.sv
package rbsu_pkg;

   // geometry
   localparam int DIMS       = 64;
   localparam int IDX_W      = $clog2(DIMS);
   localparam int VALUE_W    = 32;
   localparam int COORD_W    = 17;
   localparam int STEP_W     = 17;
   localparam int FACTOR_W   = 16;
   localparam int FRAC_SHIFT = 14;
   localparam int SUM_W      = 48;
   localparam int ITER_W     = 16;
   localparam int STALL_W    = 4;
   localparam int MOVE_W     = COORD_W + 2;
   localparam int PROD_W     = STEP_W + FACTOR_W;
   localparam int SQ_W       = 2 * COORD_W;

   // fixed point one and counter limits
   localparam logic [COORD_W-1:0] ONE_FX      = COORD_W'(65536);
   localparam logic [STALL_W-1:0] STALL_LIMIT = STALL_W'(10);
   localparam logic [STALL_W-1:0] STALL_MAX   = '1;
   localparam logic [ITER_W-1:0]  ITER_MAX    = '1;

   // command codes
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

   // queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);

   // csr port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_STEP   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROW_FACTOR    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHRINK_FACTOR  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THETA_SQUARED  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITERATIONS = 3'd4;

   // csr reset values
   localparam logic [STEP_W-1:0]   RST_INITIAL_STEP   = STEP_W'(6554);
   localparam logic [FACTOR_W-1:0] RST_GROW_FACTOR    = FACTOR_W'(19661);
   localparam logic [FACTOR_W-1:0] RST_SHRINK_FACTOR  = FACTOR_W'(8192);
   localparam logic [SUM_W-1:0]    RST_THETA_SQUARED  = SUM_W'(4295);
   localparam logic [ITER_W-1:0]   RST_MAX_ITERATIONS = ITER_W'(200);

   // stored gradient sign
   typedef enum logic [1:0] {
      SIGN_NONE = 2'd0,
      SIGN_POS  = 2'd1,
      SIGN_NEG  = 2'd3
   } sign_type;

   typedef struct packed {
      logic [STEP_W-1:0]   initial_step;
      logic [FACTOR_W-1:0] grow_factor;
      logic [FACTOR_W-1:0] shrink_factor;
      logic [SUM_W-1:0]    theta_squared;
      logic [ITER_W-1:0]   max_iterations;
   } cfg_type;

   // classified word handed from front to back
   typedef struct packed {
      logic               is_load;
      logic [IDX_W-1:0]   index;
      sign_type           sign;
      logic [COORD_W-1:0] load_coord;
      logic               last;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

// File: sv/rbsu_front.sv
module rbsu_front
   import rbsu_pkg::*;
(
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_cmd,
   input  logic [IDX_W-1:0]          req_coord_index,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last,
   input  queue_status_type          q_status,
   output logic                      push,
   output item_type                  item
);

   localparam logic signed [VALUE_W-1:0] ONE_WIDE = $signed(VALUE_W'(ONE_FX));

   logic [COORD_W-1:0] load_coord;
   sign_type           sign;

   // accept whenever the queue has room
   assign req_ready = !q_status.full;
   assign push      = req_valid && req_ready;

   // start position clamped to [0, 1.0]
   always_comb begin
      if (req_value < 0) begin
         load_coord = '0;
      end else if (req_value > ONE_WIDE) begin
         load_coord = ONE_FX;
      end else begin
         load_coord = req_value[COORD_W-1:0];
      end
   end

   // gradient sign
   always_comb begin
      if (req_value[VALUE_W-1]) begin
         sign = SIGN_NEG;
      end else if (req_value != '0) begin
         sign = SIGN_POS;
      end else begin
         sign = SIGN_NONE;
      end
   end

   always_comb begin
      item.is_load    = (req_cmd == CMD_LOAD);
      item.index      = req_coord_index;
      item.sign       = sign;
      item.load_coord = load_coord;
      item.last       = req_last;
   end

endmodule

// File: sv/rbsu_queue.sv
module rbsu_queue
   import rbsu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output item_type         head,
   output queue_status_type q_status
);

   item_type            entries_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W:0]     count_ff;

   assign head           = entries_ff[rd_ptr_ff];
   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == (QPTR_W+1)'(QDEPTH));

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= QPTR_W'(wr_ptr_ff + 1'b1);
         end
         if (pop) begin
            rd_ptr_ff <= QPTR_W'(rd_ptr_ff + 1'b1);
         end
         count_ff <= count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: sv/rbsu_back.sv
module rbsu_back
   import rbsu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  queue_status_type   q_status,
   input  item_type           head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [IDX_W-1:0]   rsp_out_index,
   output logic [COORD_W-1:0] rsp_new_coord,
   output logic [STEP_W-1:0]  rsp_new_step,
   output logic               rsp_iteration_end,
   output logic               rsp_converged,
   output logic               rsp_limit_reached
);

   localparam int SCALED_W = PROD_W - FRAC_SHIFT;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_MOVE = 5'b00100,
      ST_SQ   = 5'b01000,
      ST_SUM  = 5'b10000
   } state_type;

   typedef struct packed {
      logic [COORD_W-1:0] coord;
      logic [STEP_W-1:0]  step;
      logic [1:0]         sign;
   } entry_type;

   function automatic logic [STEP_W-1:0] sat_step(input logic signed [MOVE_W-1:0] v);
      logic [STEP_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > $signed(MOVE_W'(ONE_FX))) begin
         r = ONE_FX;
      end else begin
         r = v[STEP_W-1:0];
      end
      return r;
   endfunction

   state_type          state_ff, state_in;
   entry_type          mem [DIMS];
   logic [DIMS-1:0]    sign_valid_ff;
   item_type           op_ff;
   entry_type          rd_ff;
   logic               rd_ok_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [COORD_W-1:0] new_coord_ff;
   logic [STEP_W-1:0]  new_step_ff;
   logic [1:0]         new_sign;
   logic [COORD_W-1:0] delta_ff;
   logic [SQ_W-1:0]    sq_ff;
   logic [SUM_W-1:0]   move_sum_ff;
   logic [STALL_W-1:0] stall_ff;
   logic [ITER_W-1:0]  iter_ff;
   logic               rsp_valid_ff;
   logic [IDX_W-1:0]   rsp_index_ff;
   logic [COORD_W-1:0] rsp_coord_ff;
   logic [STEP_W-1:0]  rsp_step_ff;
   logic               rsp_iend_ff;
   logic               rsp_conv_ff;
   logic               rsp_lim_ff;

   logic                       s_pos, s_neg, p_pos, p_neg, agree, disagree;
   logic [1:0]                 psign;
   logic [FACTOR_W-1:0]        factor;
   logic [SCALED_W-1:0]        scaled;
   logic [STEP_W-1:0]          scaled_sat, st1, st_new;
   logic signed [MOVE_W-1:0]   st_s, x0_s, x1, nx, one_s;
   logic [COORD_W-1:0]         x_new, delta;
   logic [SUM_W:0]             sum_wide;
   logic [SUM_W-1:0]           sum_sat;
   logic [STALL_W-1:0]         stall_next;
   logic [ITER_W-1:0]          iter_next;
   logic                       sum_fire;

   assign pop      = (state_ff == ST_IDLE) && !q_status.empty;
   assign sum_fire = (state_ff == ST_SUM) && (!rsp_valid_ff || rsp_ready);

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (!q_status.empty) state_in = ST_MUL;
         ST_MUL:  state_in = ST_MOVE;
         ST_MOVE: state_in = ST_SQ;
         ST_SQ:   state_in = ST_SUM;
         ST_SUM:  if (sum_fire) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // sign comparison against stored sign
   always_comb begin
      psign    = rd_ok_ff ? rd_ff.sign : SIGN_NONE;
      s_pos    = (op_ff.sign == SIGN_POS);
      s_neg    = (op_ff.sign == SIGN_NEG);
      p_pos    = (psign == SIGN_POS);
      p_neg    = (psign == SIGN_NEG);
      agree    = (s_pos && p_pos) || (s_neg && p_neg);
      disagree = (s_pos && p_neg) || (s_neg && p_pos);
      factor   = agree ? cfg.grow_factor : cfg.shrink_factor;
   end

   // step scaling, move and clamp
   always_comb begin
      scaled     = prod_ff[PROD_W-1:FRAC_SHIFT];
      scaled_sat = (scaled > SCALED_W'(ONE_FX)) ? ONE_FX : scaled[STEP_W-1:0];
      st1        = (agree || disagree) ? scaled_sat : rd_ff.step;
      st_s       = $signed(MOVE_W'(st1));
      x0_s       = $signed(MOVE_W'(rd_ff.coord));
      one_s      = $signed(MOVE_W'(ONE_FX));
      if (agree) begin
         x1 = s_pos ? (x0_s - st_s) : (x0_s + st_s);
      end else begin
         x1 = x0_s;
      end
      if (s_pos) begin
         nx = x1 - st_s;
      end else if (s_neg) begin
         nx = x1 + st_s;
      end else begin
         nx = x1;
      end
      if (op_ff.is_load) begin
         x_new  = op_ff.load_coord;
         st_new = (cfg.initial_step > ONE_FX) ? ONE_FX : cfg.initial_step;
      end else if (nx < 0) begin
         x_new  = '0;
         st_new = sat_step(x1);
      end else if (nx > one_s) begin
         x_new  = ONE_FX;
         st_new = sat_step(one_s - x1);
      end else begin
         x_new  = nx[COORD_W-1:0];
         st_new = st1;
      end
      new_sign = (op_ff.is_load || disagree) ? SIGN_NONE : op_ff.sign;
      if (op_ff.is_load) begin
         delta = '0;
      end else if (rd_ff.coord > x_new) begin
         delta = rd_ff.coord - x_new;
      end else begin
         delta = x_new - rd_ff.coord;
      end
   end

   // saturating accumulate and stop counters
   always_comb begin
      sum_wide = (SUM_W+1)'(move_sum_ff) + (SUM_W+1)'(sq_ff);
      sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
      if (sum_sat < cfg.theta_squared) begin
         stall_next = (stall_ff == STALL_MAX) ? stall_ff : STALL_W'(stall_ff + 1'b1);
      end else begin
         stall_next = '0;
      end
      iter_next = (iter_ff == ITER_MAX) ? iter_ff : ITER_W'(iter_ff + 1'b1);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sign_valid_ff <= '0;
         move_sum_ff   <= '0;
         stall_ff      <= '0;
         iter_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_MOVE) begin
            sign_valid_ff[op_ff.index] <= 1'b1;
         end
         if (sum_fire && !op_ff.is_load) begin
            if (op_ff.last) begin
               stall_ff    <= stall_next;
               iter_ff     <= iter_next;
               move_sum_ff <= '0;
            end else begin
               move_sum_ff <= sum_sat;
            end
         end
         if (sum_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // coordinate memory, read on pop and written back after the move
   always_ff @(posedge clock) begin
      if (pop) begin
         rd_ff    <= mem[head.index];
         rd_ok_ff <= sign_valid_ff[head.index];
      end
      if (state_ff == ST_MOVE) begin
         mem[op_ff.index] <= '{coord: x_new, step: st_new, sign: new_sign};
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (pop) begin
         op_ff <= head;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= PROD_W'(rd_ff.step) * PROD_W'(factor);
      end
      if (state_ff == ST_MOVE) begin
         new_coord_ff <= x_new;
         new_step_ff  <= st_new;
         delta_ff     <= delta;
      end
      if (state_ff == ST_SQ) begin
         sq_ff <= SQ_W'(delta_ff) * SQ_W'(delta_ff);
      end
      if (sum_fire) begin
         rsp_index_ff <= op_ff.index;
         rsp_coord_ff <= new_coord_ff;
         rsp_step_ff  <= new_step_ff;
         rsp_iend_ff  <= !op_ff.is_load && op_ff.last;
         rsp_conv_ff  <= !op_ff.is_load && op_ff.last && (stall_next >= STALL_LIMIT);
         rsp_lim_ff   <= !op_ff.is_load && op_ff.last && (iter_next >= cfg.max_iterations);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_index     = rsp_index_ff;
   assign rsp_new_coord     = rsp_coord_ff;
   assign rsp_new_step      = rsp_step_ff;
   assign rsp_iteration_end = rsp_iend_ff;
   assign rsp_converged     = rsp_conv_ff;
   assign rsp_limit_reached = rsp_lim_ff;

endmodule

// File: sv/rprop_box_step_update_unit.sv
// an accepted word passes through the queue, then the back end sequencer, to rsp_valid
// the back end takes one word at a time and returns to idle before popping the next,
//   stepping through memory read, step scaling multiply, move and clamp, square, accumulate
// a 2-word queue lets the input side keep accepting while a result waits
// reset clears counters, stored signs, queue, output and csr defaults;
//   positions and steps are not cleared and hold garbage until loaded
module rprop_box_step_update_unit
   import rbsu_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_cmd,
   input  logic [IDX_W-1:0]          req_coord_index,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [IDX_W-1:0]          rsp_out_index,
   output logic [COORD_W-1:0]        rsp_new_coord,
   output logic [STEP_W-1:0]         rsp_new_step,
   output logic                      rsp_iteration_end,
   output logic                      rsp_converged,
   output logic                      rsp_limit_reached,
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   cfg_type          cfg_ff;
   queue_status_type q_status;
   item_type         push_item;
   item_type         head;
   logic             push;
   logic             pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.initial_step   <= RST_INITIAL_STEP;
         cfg_ff.grow_factor    <= RST_GROW_FACTOR;
         cfg_ff.shrink_factor  <= RST_SHRINK_FACTOR;
         cfg_ff.theta_squared  <= RST_THETA_SQUARED;
         cfg_ff.max_iterations <= RST_MAX_ITERATIONS;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INITIAL_STEP:   cfg_ff.initial_step   <= csr_wdata[STEP_W-1:0];
            CSR_GROW_FACTOR:    cfg_ff.grow_factor    <= csr_wdata[FACTOR_W-1:0];
            CSR_SHRINK_FACTOR:  cfg_ff.shrink_factor  <= csr_wdata[FACTOR_W-1:0];
            CSR_THETA_SQUARED:  cfg_ff.theta_squared  <= csr_wdata[SUM_W-1:0];
            CSR_MAX_ITERATIONS: cfg_ff.max_iterations <= csr_wdata[ITER_W-1:0];
            default: ;
         endcase
      end
   end

   rbsu_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_coord_index (req_coord_index),
      .req_value       (req_value),
      .req_last        (req_last),
      .q_status        (q_status),
      .push            (push),
      .item            (push_item)
   );

   rbsu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .q_status  (q_status)
   );

   rbsu_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_status          (q_status),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_index     (rsp_out_index),
      .rsp_new_coord     (rsp_new_coord),
      .rsp_new_step      (rsp_new_step),
      .rsp_iteration_end (rsp_iteration_end),
      .rsp_converged     (rsp_converged),
      .rsp_limit_reached (rsp_limit_reached)
   );

endmodule

// File: sv/rbsu_checker.sv
module rbsu_checker
   import rbsu_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_cmd,
   input logic [IDX_W-1:0]          req_coord_index,
   input logic signed [VALUE_W-1:0] req_value,
   input logic                      req_last,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [IDX_W-1:0]          rsp_out_index,
   input logic [COORD_W-1:0]        rsp_new_coord,
   input logic [STEP_W-1:0]         rsp_new_step,
   input logic                      rsp_iteration_end,
   input logic                      rsp_converged,
   input logic                      rsp_limit_reached,
   input logic                      csr_we,
   input logic [CSR_IDX_W-1:0]      csr_index,
   input logic [CSR_DATA_W-1:0]     csr_wdata
);

   // a stalled result word holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_index)
         && $stable(rsp_iteration_end))
      else $error("result word changed while stalled");

   // stop flags only on the word that closes an iteration
   a_flags_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_iteration_end |-> !rsp_converged && !rsp_limit_reached)
      else $error("stop flag without iteration end");

   // nothing offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // right after reset, with no word accepted, no result word is offered
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !(req_valid && req_ready) |=> !rsp_valid)
      else $error("result appeared without a preceding word");

endmodule

bind rprop_box_step_update_unit rbsu_checker u_checker (.*);
